// ===== hw/rtl/hmbs_pkg.sv =====
// shared types and constants for the heightmap bilinear sampler
// no dependencies; imported by the bank, the lerp unit and the top level
package hmbs_pkg;

    localparam int HEIGHT_W = 24;
    localparam int ALT_W    = 8;
    localparam int SCALE_W  = 16;
    localparam int POS_W    = 32;
    localparam int NUM_BANKS = 4;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd1;

    typedef enum logic
    {
        OP_WRITE  = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    // load enables for the two register stages of one lerp unit
    typedef struct packed
    {
        logic mul_en;
        logic sum_en;
    } lerp_ctl_t;

endpackage

// ===== hw/rtl/heightmap_bilinear_sampler_core.sv =====
// top level of the wrapped heightmap bilinear sampler
// depends on hmbs_pkg, hmbs_bank (four map banks) and hmbs_lerp (three blend units)
//
//  channel   direction  payload (low bit first)                    transfers
//  s_axis    in         tuser: op; tdata: pos_x, pos_z, alt_value  write or sample item
//  m_axis    out        tdata: height                              one per sample
//  cfg_wr    in         cfg_wr_data: height_scale                  single register write
//
// six register stages: bank read, scale, x products, x sum, z products, z sum
// one item enters per cycle unless m_axis back-pressure has filled the stages; a sample's
// height is valid once it reaches the z sum stage and is held there until m_axis takes it
// a write updates its bank at its transfer edge and is visible to the next item
// each stage loads when it is empty or the stage after it moves, so bubbles are squeezed out
// reset clears the valid bits and sets the scale to one; map contents are undefined
module heightmap_bilinear_sampler_core #(
    parameter int TILE_BITS  = 10,
    parameter int MAP_X_BITS = 8,
    parameter int MAP_Z_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [71:0]                   s_axis_tdata,  // pos_x, pos_z, alt_value
    input  logic                          s_axis_tuser,  // op
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [hmbs_pkg::HEIGHT_W-1:0] m_axis_tdata,  // height
    input  logic                          cfg_wr_en,
    input  logic [hmbs_pkg::SCALE_W-1:0]  cfg_wr_data
);
    import hmbs_pkg::*;

    localparam int FULL_W = MAP_X_BITS + MAP_Z_BITS;
    localparam int BANK_AW = (FULL_W > 2) ? FULL_W - 2 : 1;

    // input unpacking
    logic [POS_W-1:0]      pos_x;
    logic [POS_W-1:0]      pos_z;
    logic [ALT_W-1:0]      alt_value;
    op_t                   op;
    logic                  s_xfer;

    assign pos_x     = s_axis_tdata[31:0];
    assign pos_z     = s_axis_tdata[63:32];
    assign alt_value = s_axis_tdata[71:64];
    assign op        = op_t'(s_axis_tuser);
    assign s_xfer    = s_axis_tvalid & s_axis_tready;

    // stage enables and valid bits
    logic en1, en2, en3, en4, en5, en6;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;

    assign en6 = ~v6_reg | m_axis_tready;
    assign en5 = ~v5_reg | en6;
    assign en4 = ~v4_reg | en5;
    assign en3 = ~v3_reg | en4;
    assign en2 = ~v2_reg | en3;
    assign en1 = ~v1_reg | en2;
    assign s_axis_tready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= s_xfer & (op == OP_SAMPLE);
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
        end
    end

    // height scale register
    logic [SCALE_W-1:0] scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
        end
        else if (cfg_wr_en)
        begin
            scale_reg <= cfg_wr_data;
        end
    end

    // bank addressing: bank = {z parity, x parity}, so the four corners never collide
    logic [MAP_X_BITS-1:0] wx, tx, tx2, sel_x;
    logic [MAP_Z_BITS-1:0] wz, tz, tz2, sel_z;
    logic [FULL_W-1:0]     waddr_full;
    logic [FULL_W-1:0]     raddr_full [NUM_BANKS];
    logic [BANK_AW-1:0]    raddr [NUM_BANKS];
    logic [BANK_AW-1:0]    waddr;
    logic [1:0]            wbank;
    logic                  xp, zp;
    logic [NUM_BANKS-1:0]  bank_we;
    logic [ALT_W-1:0]      rdata [NUM_BANKS];

    always_comb
    begin
        wx    = pos_x[MAP_X_BITS-1:0];
        wz    = pos_z[MAP_Z_BITS-1:0];
        tx    = pos_x[TILE_BITS +: MAP_X_BITS];
        tz    = pos_z[TILE_BITS +: MAP_Z_BITS];
        tx2   = tx + MAP_X_BITS'(1);
        tz2   = tz + MAP_Z_BITS'(1);
        xp    = tx[0];
        zp    = tz[0];
        wbank = {wz[0], wx[0]};
        waddr_full = ((FULL_W'(wz) >> 1) << (MAP_X_BITS - 1)) | (FULL_W'(wx) >> 1);
        waddr = waddr_full[BANK_AW-1:0];
        sel_x = tx;
        sel_z = tz;
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            sel_x = (b[0] == xp) ? tx : tx2;
            sel_z = (b[1] == zp) ? tz : tz2;
            raddr_full[2'(b)] = ((FULL_W'(sel_z) >> 1) << (MAP_X_BITS - 1)) |
                                (FULL_W'(sel_x) >> 1);
            raddr[2'(b)] = raddr_full[2'(b)][BANK_AW-1:0];
            bank_we[2'(b)] = s_xfer && (op == OP_WRITE) && (wbank == 2'(b));
        end
    end

    genvar gb;
    generate
        for (gb = 0; gb < NUM_BANKS; gb++)
        begin : g_bank
            hmbs_bank #(
                .ADDR_W (BANK_AW)
            ) u_bank (
                .clk   (clk),
                .we    (bank_we[gb]),
                .waddr (waddr),
                .wdata (alt_value),
                .re    (s_xfer && (op == OP_SAMPLE)),
                .raddr (raddr[gb]),
                .rdata (rdata[gb])
            );
        end
    endgenerate

    // stage 1 side data
    logic [TILE_BITS-1:0] ox1_reg, oz1_reg;
    logic                 xp1_reg, zp1_reg;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            ox1_reg <= pos_x[TILE_BITS-1:0];
            oz1_reg <= pos_z[TILE_BITS-1:0];
            xp1_reg <= xp;
            zp1_reg <= zp;
        end
    end

    // stage 2: route bank outputs to corners and scale
    logic [HEIGHT_W-1:0]  y00_next, y10_next, y01_next, y11_next;
    logic [HEIGHT_W-1:0]  y00_reg, y10_reg, y01_reg, y11_reg;
    logic [TILE_BITS-1:0] ox2_reg, oz2_reg;

    always_comb
    begin
        y00_next = HEIGHT_W'(rdata[{zp1_reg, xp1_reg}])   * HEIGHT_W'(scale_reg);
        y10_next = HEIGHT_W'(rdata[{zp1_reg, ~xp1_reg}])  * HEIGHT_W'(scale_reg);
        y01_next = HEIGHT_W'(rdata[{~zp1_reg, xp1_reg}])  * HEIGHT_W'(scale_reg);
        y11_next = HEIGHT_W'(rdata[{~zp1_reg, ~xp1_reg}]) * HEIGHT_W'(scale_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            y00_reg <= y00_next;
            y10_reg <= y10_next;
            y01_reg <= y01_next;
            y11_reg <= y11_next;
            ox2_reg <= ox1_reg;
            oz2_reg <= oz1_reg;
        end
    end

    // stages 3 and 4: blend along x; z offset rides alongside
    logic [TILE_BITS-1:0] oz3_reg, oz4_reg;
    logic [HEIGHT_W-1:0]  y0, y1;
    lerp_ctl_t            ctl_x, ctl_z;

    assign ctl_x = '{mul_en: en3, sum_en: en4};
    assign ctl_z = '{mul_en: en5, sum_en: en6};

    always_ff @(posedge clk)
    begin
        if (en3) oz3_reg <= oz2_reg;
        if (en4) oz4_reg <= oz3_reg;
    end

    hmbs_lerp #(
        .TILE_BITS (TILE_BITS)
    ) u_lerp_x0 (
        .clk (clk),
        .ctl (ctl_x),
        .a   (y00_reg),
        .b   (y10_reg),
        .off (ox2_reg),
        .y   (y0)
    );

    hmbs_lerp #(
        .TILE_BITS (TILE_BITS)
    ) u_lerp_x1 (
        .clk (clk),
        .ctl (ctl_x),
        .a   (y01_reg),
        .b   (y11_reg),
        .off (ox2_reg),
        .y   (y1)
    );

    // stages 5 and 6: blend along z into the output register
    hmbs_lerp #(
        .TILE_BITS (TILE_BITS)
    ) u_lerp_z (
        .clk (clk),
        .ctl (ctl_z),
        .a   (y0),
        .b   (y1),
        .off (oz4_reg),
        .y   (m_axis_tdata)
    );

    assign m_axis_tvalid = v6_reg;

    // a bubble in the first stage must never hold off the input
    a_ready_on_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        !v1_reg |-> s_axis_tready)
        else $error("input stalled with empty first stage");

    // a write transfer never enters the result pipeline
    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_xfer && (op == OP_WRITE)) |=> !v1_reg)
        else $error("write transfer produced a pipeline entry");

    // a new result only arrives from the stage before it
    a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(v5_reg))
        else $error("result valid without a preceding stage item");

endmodule

// ===== hw/rtl/hmbs_bank.sv =====
// one bank of the altitude map: one write port, one registered read port
// depends on hmbs_pkg for the altitude width
module hmbs_bank #(
    parameter int ADDR_W = 14
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [ADDR_W-1:0]          waddr,
    input  logic [hmbs_pkg::ALT_W-1:0] wdata,
    input  logic                       re,
    input  logic [ADDR_W-1:0]          raddr,
    output logic [hmbs_pkg::ALT_W-1:0] rdata
);
    import hmbs_pkg::*;

    logic [ALT_W-1:0] mem [0:(1 << ADDR_W)-1];
    logic [ALT_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/hmbs_lerp.sv =====
// two-stage linear blend ((2^tb - off) * a + off * b) >> tb
// stage one holds the two products, stage two the shifted sum; uses hmbs_pkg
module hmbs_lerp #(
    parameter int TILE_BITS = 10
) (
    input  logic                          clk,
    input  hmbs_pkg::lerp_ctl_t           ctl,
    input  logic [hmbs_pkg::HEIGHT_W-1:0] a,
    input  logic [hmbs_pkg::HEIGHT_W-1:0] b,
    input  logic [TILE_BITS-1:0]          off,
    output logic [hmbs_pkg::HEIGHT_W-1:0] y
);
    import hmbs_pkg::*;

    localparam int WT_W = TILE_BITS + 1;
    localparam int PROD_W = HEIGHT_W + WT_W;
    localparam logic [WT_W-1:0] TILE_SIZE = WT_W'(1) << TILE_BITS;

    logic [WT_W-1:0]     wt_a;
    logic [PROD_W-1:0]   pa_next;
    logic [PROD_W-1:0]   pb_next;
    logic [PROD_W-1:0]   pa_reg;
    logic [PROD_W-1:0]   pb_reg;
    logic [PROD_W:0]     sum;
    logic [HEIGHT_W-1:0] y_next;
    logic [HEIGHT_W-1:0] y_reg;

    always_comb
    begin
        wt_a    = TILE_SIZE - {1'b0, off};
        pa_next = PROD_W'(wt_a) * PROD_W'(a);
        pb_next = PROD_W'(off) * PROD_W'(b);
        sum     = {1'b0, pa_reg} + {1'b0, pb_reg};
        // result never exceeds max(a, b), so the slice loses nothing
        y_next  = sum[TILE_BITS +: HEIGHT_W];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            pa_reg <= pa_next;
            pb_reg <= pb_next;
        end
        if (ctl.sum_en)
        begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule

// ===== bench/tb_heightmap_bilinear_sampler_core.sv =====
// self-checking bench for heightmap_bilinear_sampler_core: directed and random traffic
// depends on hmbs_pkg and the core; holds its own altitude map and blend predictor
`timescale 1ns / 100ps

module tb_heightmap_bilinear_sampler_core;

    import hmbs_pkg::*;

    localparam int TILE_BITS    = 10;
    localparam int MAP_X_BITS   = 8;
    localparam int MAP_Z_BITS   = 8;
    localparam int IDX_W        = MAP_X_BITS + MAP_Z_BITS;
    localparam int MAP_ENTRIES  = 1 << (MAP_X_BITS + MAP_Z_BITS);
    localparam longint unsigned TILE_SIZE = 64'd1 << TILE_BITS;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_ITEMS = 880;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [71:0]         s_axis_tdata  = '0;   // pos_x, pos_z, alt_value
    logic                s_axis_tuser  = 1'b0; // op
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [HEIGHT_W-1:0] m_axis_tdata;         // height
    logic                cfg_wr_en     = 1'b0;
    logic [SCALE_W-1:0]  cfg_wr_data   = '0;

    // predictor state
    logic [ALT_W-1:0]    altitude_copy [0:MAP_ENTRIES-1];
    bit                  tile_written  [0:MAP_ENTRIES-1];
    logic [SCALE_W-1:0]  scale_now = SCALE_RESET;
    logic [HEIGHT_W-1:0] pending_heights [$];

    int  items_sent     = 0;
    int  samples_sent   = 0;
    int  heights_seen   = 0;
    int  error_count    = 0;
    int  scale_settings = 0;
    int  rx_wait        = 0;
    bit  tx_no_gap      = 1'b0;
    bit  rx_no_stall    = 1'b0;

    heightmap_bilinear_sampler_core #(
        .TILE_BITS  (TILE_BITS),
        .MAP_X_BITS (MAP_X_BITS),
        .MAP_Z_BITS (MAP_Z_BITS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #(5_000_000);
        $display("simulation failed");
        $finish;
    end

    function automatic logic [HEIGHT_W-1:0] predict_height(input logic [POS_W-1:0] px,
                                                           input logic [POS_W-1:0] pz);
        longint unsigned ox, oz, y00, y01, y10, y11, y0, y1, h;
        logic [MAP_X_BITS-1:0] x, x2;
        logic [MAP_Z_BITS-1:0] z, z2;
        begin
            ox  = 64'(px[TILE_BITS-1:0]);
            oz  = 64'(pz[TILE_BITS-1:0]);
            x   = px[TILE_BITS +: MAP_X_BITS];
            z   = pz[TILE_BITS +: MAP_Z_BITS];
            x2  = x + MAP_X_BITS'(1);
            z2  = z + MAP_Z_BITS'(1);
            y00 = longint'(altitude_copy[{z, x}]) * longint'(scale_now);
            y01 = longint'(altitude_copy[{z2, x}]) * longint'(scale_now);
            y10 = longint'(altitude_copy[{z, x2}]) * longint'(scale_now);
            y11 = longint'(altitude_copy[{z2, x2}]) * longint'(scale_now);
            y0  = ((TILE_SIZE - ox) * y00 + ox * y10) >> TILE_BITS;
            y1  = ((TILE_SIZE - ox) * y01 + ox * y11) >> TILE_BITS;
            h   = ((TILE_SIZE - oz) * y0 + oz * y1) >> TILE_BITS;
            return h[HEIGHT_W-1:0];
        end
    endfunction

    // one input transfer; the predictor is updated at the accepting edge
    task automatic send_item(input op_t op, input logic [POS_W-1:0] px,
                             input logic [POS_W-1:0] pz, input logic [ALT_W-1:0] alt);
        int gap;
        logic [MAP_X_BITS+MAP_Z_BITS-1:0] idx;
        begin
            gap = tx_no_gap ? 0 : $urandom_range(0, 9);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {alt, pz, px};
            s_axis_tuser  <= op;
            @(posedge clk);
            while (!s_axis_tready) @(posedge clk);
            if (op == OP_WRITE)
            begin
                idx = {pz[MAP_Z_BITS-1:0], px[MAP_X_BITS-1:0]};
                altitude_copy[idx] = alt;
                tile_written[idx]  = 1'b1;
            end
            else
            begin
                pending_heights.push_back(predict_height(px, pz));
                samples_sent++;
            end
            items_sent++;
        end
    endtask

    // writes leave nothing to wait for, so allow the pipeline depth on top
    task automatic wait_for_idle;
        begin
            s_axis_tvalid <= 1'b0;
            while (pending_heights.size() != 0) @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    task automatic set_height_scale(input logic [SCALE_W-1:0] value);
        begin
            wait_for_idle();
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= value;
            @(posedge clk);
            cfg_wr_en   <= 1'b0;
            scale_now = value;
            scale_settings++;
        end
    endtask

    // result side: check every transfer, then stall for a random count unless rx_no_stall is set
    always @(posedge clk)
    begin : height_checker
        logic [HEIGHT_W-1:0] want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_heights.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected height, expected none, actual %0d",
                             $time, m_axis_tdata);
                end
                else
                begin
                    want = pending_heights.pop_front();
                    heights_seen++;
                    if (m_axis_tdata !== want)
                    begin
                        error_count++;
                        $display("%0t: height mismatch, expected %0d, actual %0d",
                                 $time, want, m_axis_tdata);
                    end
                end
                rx_wait = rx_no_stall ? 0 : $urandom_range(0, 9);
            end
            if (rx_wait == 0)
                m_axis_tready <= 1'b1;
            else
            begin
                m_axis_tready <= 1'b0;
                rx_wait--;
            end
        end
    end

    // four corners around tile (0,0), reset scale, offsets at both ends and the middle
    task automatic test_basic_blend;
        begin
            send_item(OP_WRITE, 32'hFFFF_FF00, 32'h0000_0000, 8'd0);
            send_item(OP_WRITE, 32'hFFFF_FF01, 32'hAB00_0000, 8'd255);
            send_item(OP_WRITE, 32'h1234_5600, 32'h0000_0001, 8'd128);
            send_item(OP_WRITE, 32'h0000_0001, 32'hFFFF_FF01, 8'd255);
            send_item(OP_SAMPLE, 32'hABC0_0000, 32'h5430_0000, 8'hFF);
            send_item(OP_SAMPLE, 32'hABC0_03FF, 32'h5430_0000, 8'h00);
            send_item(OP_SAMPLE, 32'hABC0_0000, 32'h5430_03FF, 8'hFF);
            send_item(OP_SAMPLE, 32'hABC0_03FF, 32'h5430_03FF, 8'h00);
            send_item(OP_SAMPLE, 32'h0000_0200, 32'h0000_0200, 8'hA5);
        end
    endtask

    // neighbours past the last tile wrap to tile 0; high index bits of writes are dropped
    task automatic test_edge_wrap;
        begin
            tx_no_gap = 1'b1;
            send_item(OP_WRITE, 32'h0000_00FF, 32'h1234_56FF, 8'd255);
            send_item(OP_WRITE, 32'hFFFF_FF00, 32'h0000_00FF, 8'd1);
            send_item(OP_WRITE, 32'h7F00_00FF, 32'h8000_0000, 8'd200);
            send_item(OP_WRITE, 32'hFFFF_FF00, 32'hFFFF_FF00, 8'd77);
            send_item(OP_SAMPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00);
            send_item(OP_SAMPLE, 32'h0003_FC00, 32'h0003_FC00, 8'hFF);
            send_item(OP_SAMPLE, 32'h8003_FE00, 32'h7FFF_FC01, 8'h5A);
            tx_no_gap = 1'b0;
        end
    endtask

    // full-scale altitudes at the largest multiplier, then a zero multiplier
    task automatic test_scale_extremes;
        begin
            set_height_scale(16'hFFFF);
            send_item(OP_WRITE, 32'h0000_0000, 32'h0000_0000, 8'd255);
            send_item(OP_WRITE, 32'h0000_0001, 32'h0000_0000, 8'd255);
            send_item(OP_WRITE, 32'h0000_0000, 32'h0000_0001, 8'd255);
            send_item(OP_WRITE, 32'h0000_0001, 32'h0000_0001, 8'd255);
            send_item(OP_SAMPLE, 32'h0000_0000, 32'h0000_0000, 8'h00);
            send_item(OP_SAMPLE, 32'hFFFC_03FF, 32'hFFFC_03FF, 8'hFF);
            set_height_scale(16'h0000);
            send_item(OP_SAMPLE, 32'h0000_0200, 32'h0000_0155, 8'h3C);
        end
    endtask

    // samples always preceded by writes of any corner not yet stored
    task automatic test_random_traffic;
        int start;
        int dx, dz;
        logic [POS_W-1:0]      px, pz;
        logic [MAP_X_BITS-1:0] tx, wx;
        logic [MAP_Z_BITS-1:0] tz, wz;
        logic [TILE_BITS-1:0]  offx, offz;
        begin
            start = items_sent;
            set_height_scale(16'd1);
            while (items_sent - start < RANDOM_ITEMS)
            begin
                if ($urandom_range(0, 149) == 0)
                begin
                    case ($urandom_range(0, 3))
                        0:       set_height_scale(16'd1);
                        1:       set_height_scale(16'hFFFF);
                        default: set_height_scale(SCALE_W'($urandom_range(1, 65535)));
                    endcase
                end
                else if ($urandom_range(0, 99) == 0)
                    wait_for_idle();
                if ($urandom_range(0, 79) == 0)
                begin
                    tx_no_gap   = ($urandom_range(0, 2) == 0);
                    rx_no_stall = ($urandom_range(0, 2) == 0);
                end
                if ($urandom_range(0, 9) < 2)
                    send_item(OP_WRITE, $urandom(), $urandom(),
                              ALT_W'($urandom_range(0, 255)));
                else
                begin
                    case ($urandom_range(0, 3))
                        0:       tx = $urandom_range(0, 1) ? '1 : '0;
                        1:       tx = MAP_X_BITS'($urandom_range(0, 7));
                        default: tx = MAP_X_BITS'($urandom());
                    endcase
                    case ($urandom_range(0, 3))
                        0:       tz = $urandom_range(0, 1) ? '1 : '0;
                        1:       tz = MAP_Z_BITS'($urandom_range(0, 7));
                        default: tz = MAP_Z_BITS'($urandom());
                    endcase
                    for (dz = 0; dz < 2; dz++)
                    begin
                        for (dx = 0; dx < 2; dx++)
                        begin
                            wx = tx;
                            wz = tz;
                            if (dx != 0)
                                wx = wx + MAP_X_BITS'(1);
                            if (dz != 0)
                                wz = wz + MAP_Z_BITS'(1);
                            if (!tile_written[{wz, wx}])
                            begin
                                px = $urandom();
                                pz = $urandom();
                                px[MAP_X_BITS-1:0] = wx;
                                pz[MAP_Z_BITS-1:0] = wz;
                                send_item(OP_WRITE, px, pz, ALT_W'($urandom_range(0, 255)));
                            end
                        end
                    end
                    case ($urandom_range(0, 3))
                        0:       offx = '0;
                        1:       offx = '1;
                        default: offx = TILE_BITS'($urandom());
                    endcase
                    case ($urandom_range(0, 3))
                        0:       offz = '0;
                        1:       offz = '1;
                        default: offz = TILE_BITS'($urandom());
                    endcase
                    px = $urandom();
                    pz = $urandom();
                    px[TILE_BITS +: MAP_X_BITS] = tx;
                    pz[TILE_BITS +: MAP_Z_BITS] = tz;
                    px[TILE_BITS-1:0] = offx;
                    pz[TILE_BITS-1:0] = offz;
                    send_item(OP_SAMPLE, px, pz, ALT_W'($urandom_range(0, 255)));
                end
            end
            tx_no_gap   = 1'b0;
            rx_no_stall = 1'b0;
        end
    endtask

    initial
    begin
        for (int i = 0; i < MAP_ENTRIES; i++)
        begin
            altitude_copy[IDX_W'(i)] = '0;
            tile_written[IDX_W'(i)]  = 1'b0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_blend();
        test_edge_wrap();
        test_scale_extremes();
        test_random_traffic();
        wait_for_idle();

        $display("%0d input transfers (%0d samples), %0d heights checked",
                 items_sent, samples_sent, heights_seen);
        $display("%0d scale settings including zero and full scale, map edges wrapped",
                 scale_settings);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
